### design/ihex_pkg.sv
package ihex_pkg;

   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [31:0] MEMORY_SIZE_RESET = 32'd131072;

   localparam logic [7:0] REC_DATA    = 8'h00;
   localparam logic [7:0] REC_END     = 8'h01;
   localparam logic [7:0] REC_SEGMENT = 8'h02;
   localparam logic [7:0] REC_LINEAR  = 8'h04;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_DONE   = 2'd1;
   localparam logic [1:0] KIND_FAILED = 2'd2;

   localparam logic [1:0] FAIL_NOT_HEX    = 2'd0;
   localparam logic [1:0] FAIL_LINE_SHORT = 2'd1;
   localparam logic [1:0] FAIL_CHECKSUM   = 2'd2;
   localparam logic [1:0] FAIL_RANGE      = 2'd3;

   localparam logic CSR_BASE_ADDRESS = 1'b0;
   localparam logic CSR_MEMORY_SIZE  = 1'b1;

   typedef enum logic [2:0] {
      PHASE_LINE_START,
      PHASE_SKIP,
      PHASE_HEADER,
      PHASE_DATA,
      PHASE_CHECKSUM,
      PHASE_TAIL
   } phase_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       final_char;
   } char_item_type;

   typedef struct packed {
      logic [31:0] base_address;
      logic [31:0] memory_size;
   } cfg_type;

   // Bit 4 is set for a valid hex digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] result;
      result = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         result = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         result = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         result = {1'b1, 4'(c - 8'h57)};
      end
      return result;
   endfunction

endpackage

### design/ihex_channels.sv
interface ihex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       final_char;
   modport source (output valid, output text_char, output final_char, input ready);
   modport sink (input valid, input text_char, input final_char, output ready);
endinterface

interface ihex_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] write_offset;
   logic [7:0]  write_byte;
   logic [1:0]  fail_code;
   modport source (output valid, output result_kind, output write_offset,
                   output write_byte, output fail_code, input ready);
   modport sink (input valid, input result_kind, input write_offset,
                 input write_byte, input fail_code, output ready);
endinterface

interface ihex_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### design/intel_hex_record_parser_top.sv
// Intel HEX record parser.
// The req_ch channel carries one character of file text per transfer, with
// final_char set on the last character of the file. The rsp_ch channel
// returns at most one result per character: a byte write with its buffer
// offset, load done, or load failed with a code. After done or failed the
// parser ignores text until a character with final_char set rearms it.
// The csr_ch channel writes base_address (index 0) and memory_size
// (index 1) and is always ready; the user is to write it only while the
// parser idles, and the block itself does not enforce this.
// A character enters an input register, is parsed by one pass of logic and
// its result is loaded into the output register, where it waits until it
// is transferred. One character is taken per cycle while the output
// register is free or draining; one parse step handles each character.
// When the receiver stalls, the output register holds its result and the
// input register takes one more character, then req_ch.ready drops.
// Synchronous reset empties both registers, rearms the parser and restores
// the configuration defaults (base 0, memory size 131072 bytes).
module intel_hex_record_parser_top
   import ihex_pkg::*;
(
   input logic         clock,
   input logic         reset,
   ihex_req_if.sink    req_ch,
   ihex_rsp_if.source  rsp_ch,
   ihex_csr_if.sink    csr_ch
);

   cfg_type       cfg;
   logic          take;
   logic          item_valid;
   char_item_type item;

   ihex_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   ihex_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   ihex_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp        (rsp_ch)
   );

endmodule

### design/ihex_csr.sv
module ihex_csr
   import ihex_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ihex_csr_if.sink   csr,
   output cfg_type    cfg
);

   logic [31:0] base_address_ff;
   logic [31:0] memory_size_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= 32'd0;
         memory_size_ff  <= MEMORY_SIZE_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_BASE_ADDRESS: base_address_ff <= csr.data;
            CSR_MEMORY_SIZE:  memory_size_ff  <= csr.data;
         endcase
      end
   end

   assign cfg.base_address = base_address_ff;
   assign cfg.memory_size  = memory_size_ff;

endmodule

### design/ihex_input_reg.sv
module ihex_input_reg
   import ihex_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ihex_req_if.sink      req,
   input  logic          take,
   output logic          item_valid,
   output char_item_type item
);

   logic          valid_ff;
   char_item_type item_ff;
   logic          load;

   assign req.ready = !valid_ff || take;
   assign load      = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.text_char  <= req.text_char;
         item_ff.final_char <= req.final_char;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### design/ihex_parser.sv
module ihex_parser
   import ihex_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          item_valid,
   input  char_item_type item,
   output logic          take,
   ihex_rsp_if.source    rsp
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic        digit_odd_ff, digit_odd_in;
   logic [7:0]  record_length_ff, record_length_in;
   logic [7:0]  offset_high_ff, offset_high_in;
   logic [7:0]  record_type_ff, record_type_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [15:0] first_two_ff, first_two_in;
   logic [19:0] segment_ff, segment_in;
   logic [15:0] linear_ff, linear_in;
   logic        range_fault_ff, range_fault_in;
   logic        finished_ff, finished_in;
   logic [31:0] start_ff, start_in;

   logic        rsp_valid_ff;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] offset_ff, offset_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  code_ff, code_in;
   logic        emit;

   assign take = item_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      logic [4:0]  digit;
      logic [7:0]  b;
      logic [7:0]  index_next;
      logic [32:0] span_end;
      logic        has_fail;
      logic        done;
      logic        wr;
      logic        fin;
      logic        rearm;
      logic        clear;

      phase_in         = phase_ff;
      high_nibble_in   = high_nibble_ff;
      digit_odd_in     = digit_odd_ff;
      record_length_in = record_length_ff;
      offset_high_in   = offset_high_ff;
      record_type_in   = record_type_ff;
      running_sum_in   = running_sum_ff;
      byte_index_in    = byte_index_ff;
      first_two_in     = first_two_ff;
      segment_in       = segment_ff;
      linear_in        = linear_ff;
      range_fault_in   = range_fault_ff;
      finished_in      = finished_ff;
      start_in         = start_ff;
      kind_in          = KIND_WRITE;
      offset_in        = 32'd0;
      byte_in          = 8'd0;
      code_in          = FAIL_NOT_HEX;
      emit             = 1'b0;

      digit      = hex_digit(item.text_char);
      b          = {high_nibble_ff, digit[3:0]};
      index_next = byte_index_ff + 8'd1;
      span_end   = {1'b0, start_ff} + {25'd0, record_length_ff};
      has_fail   = 1'b0;
      done       = 1'b0;
      wr         = 1'b0;
      fin        = item.final_char;
      rearm      = 1'b0;
      clear      = 1'b0;

      if (finished_ff) begin
         rearm = fin;
      end else begin
         unique case (phase_ff)
            PHASE_LINE_START: begin
               if (item.text_char == CHAR_COLON) begin
                  clear    = 1'b1;
                  phase_in = PHASE_HEADER;
               end else if (item.text_char != CHAR_NEWLINE) begin
                  phase_in = PHASE_SKIP;
               end
            end
            PHASE_SKIP, PHASE_TAIL: begin
               if (item.text_char == CHAR_NEWLINE) begin
                  phase_in = PHASE_LINE_START;
               end
            end
            PHASE_HEADER, PHASE_DATA, PHASE_CHECKSUM: begin
               if (item.text_char == CHAR_NEWLINE) begin
                  has_fail = 1'b1;
                  code_in  = FAIL_LINE_SHORT;
               end else if (!digit[4]) begin
                  has_fail = 1'b1;
                  code_in  = FAIL_NOT_HEX;
               end else if (!digit_odd_ff) begin
                  high_nibble_in = digit[3:0];
                  digit_odd_in   = 1'b1;
               end else begin
                  digit_odd_in   = 1'b0;
                  running_sum_in = running_sum_ff + b;
                  if (phase_ff == PHASE_HEADER) begin
                     byte_index_in = index_next;
                     unique case (byte_index_ff[1:0])
                        2'd0: record_length_in = b;
                        2'd1: offset_high_in   = b;
                        2'd2: begin
                           start_in = {linear_ff, 16'd0} + {12'd0, segment_ff}
                                    + {16'd0, offset_high_ff, b} - cfg.base_address;
                        end
                        2'd3: begin
                           record_type_in = b;
                           byte_index_in  = 8'd0;
                           if (b == REC_DATA) begin
                              range_fault_in = span_end > {1'b0, cfg.memory_size};
                           end
                           phase_in = (record_length_ff != 8'd0) ? PHASE_DATA
                                                                 : PHASE_CHECKSUM;
                        end
                     endcase
                  end else if (phase_ff == PHASE_DATA) begin
                     if (byte_index_ff == 8'd0) begin
                        first_two_in = {b, 8'd0};
                     end else if (byte_index_ff == 8'd1) begin
                        first_two_in = {first_two_ff[15:8], b};
                     end
                     if (record_type_ff == REC_DATA && !range_fault_ff) begin
                        wr        = 1'b1;
                        offset_in = start_ff + {24'd0, byte_index_ff};
                        byte_in   = b;
                     end
                     byte_index_in = index_next;
                     if (index_next >= record_length_ff) begin
                        phase_in = PHASE_CHECKSUM;
                     end
                  end else begin
                     phase_in = PHASE_TAIL;
                     if (running_sum_in != 8'd0) begin
                        has_fail = 1'b1;
                        code_in  = FAIL_CHECKSUM;
                     end else if (range_fault_ff) begin
                        has_fail = 1'b1;
                        code_in  = FAIL_RANGE;
                     end else if (record_type_ff == REC_END) begin
                        done = 1'b1;
                     end else if (record_type_ff == REC_SEGMENT) begin
                        segment_in = {first_two_ff, 4'd0};
                     end else if (record_type_ff == REC_LINEAR) begin
                        linear_in = first_two_ff;
                     end
                  end
               end
            end
            default: phase_in = PHASE_LINE_START;
         endcase

         if (!has_fail && fin && (phase_in == PHASE_HEADER || phase_in == PHASE_DATA
                                  || phase_in == PHASE_CHECKSUM)) begin
            has_fail = 1'b1;
            code_in  = FAIL_LINE_SHORT;
         end

         if (has_fail) begin
            emit        = 1'b1;
            kind_in     = KIND_FAILED;
            offset_in   = 32'd0;
            byte_in     = 8'd0;
            finished_in = 1'b1;
         end else if (done || fin) begin
            emit        = 1'b1;
            kind_in     = KIND_DONE;
            offset_in   = 32'd0;
            byte_in     = 8'd0;
            code_in     = FAIL_NOT_HEX;
            finished_in = 1'b1;
         end else if (wr) begin
            emit    = 1'b1;
            code_in = FAIL_NOT_HEX;
         end
         rearm = emit && fin;
      end

      if (clear || rearm) begin
         high_nibble_in   = 4'd0;
         digit_odd_in     = 1'b0;
         record_length_in = 8'd0;
         offset_high_in   = 8'd0;
         record_type_in   = 8'd0;
         running_sum_in   = 8'd0;
         byte_index_in    = 8'd0;
         first_two_in     = 16'd0;
         range_fault_in   = 1'b0;
         start_in         = 32'd0;
      end
      if (rearm) begin
         phase_in    = PHASE_LINE_START;
         segment_in  = 20'd0;
         linear_in   = 16'd0;
         finished_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_LINE_START;
         high_nibble_ff   <= 4'd0;
         digit_odd_ff     <= 1'b0;
         record_length_ff <= 8'd0;
         offset_high_ff   <= 8'd0;
         record_type_ff   <= 8'd0;
         running_sum_ff   <= 8'd0;
         byte_index_ff    <= 8'd0;
         first_two_ff     <= 16'd0;
         segment_ff       <= 20'd0;
         linear_ff        <= 16'd0;
         range_fault_ff   <= 1'b0;
         finished_ff      <= 1'b0;
         start_ff         <= 32'd0;
      end else if (take) begin
         phase_ff         <= phase_in;
         high_nibble_ff   <= high_nibble_in;
         digit_odd_ff     <= digit_odd_in;
         record_length_ff <= record_length_in;
         offset_high_ff   <= offset_high_in;
         record_type_ff   <= record_type_in;
         running_sum_ff   <= running_sum_in;
         byte_index_ff    <= byte_index_in;
         first_two_ff     <= first_two_in;
         segment_ff       <= segment_in;
         linear_ff        <= linear_in;
         range_fault_ff   <= range_fault_in;
         finished_ff      <= finished_in;
         start_ff         <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= emit;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         kind_ff   <= kind_in;
         offset_ff <= offset_in;
         byte_ff   <= byte_in;
         code_ff   <= code_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_kind  = kind_ff;
   assign rsp.write_offset = offset_ff;
   assign rsp.write_byte   = byte_ff;
   assign rsp.fail_code    = code_ff;

endmodule
